>>> sv/ols_pkg.sv
package ols_pkg;

    localparam int LIST_DEPTH = 64;
    localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int POS_W      = 8;
    localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int DATA_W     = 32;
    localparam int MODE_W     = 3;
    localparam int STATUS_W   = 2;
    localparam int LEN_W      = 7;

    typedef enum logic [MODE_W-1:0] {
        MODE_APPEND = 3'd0,
        MODE_GET    = 3'd1,
        MODE_REMOVE = 3'd2,
        MODE_MAX    = 3'd3,
        MODE_CLEAR  = 3'd4
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } state_t;

    // Broadcast control from the sequencer to every cell in the chain.
    typedef struct packed {
        logic                     append_we;
        logic                     remove_shift;
        logic                     scan_load;
        logic                     scan_mask;
        logic                     scan_shift;
        logic                     scan_max;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         position;
        logic [CNT_W-1:0]         count;
    } cell_ctrl_t;

endpackage

>>> sv/ols_cmd_if.sv
interface ols_cmd_if;
    import ols_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [MODE_W-1:0]        mode;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value_in;

    modport source (output valid, output mode, output position, output value_in,
                    input ready);
    modport sink   (input valid, input mode, input position, input value_in,
                    output ready);
endinterface

>>> sv/ols_rsp_if.sv
interface ols_rsp_if;
    import ols_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] value_out;
    logic [STATUS_W-1:0]      status;
    logic [LEN_W-1:0]         length;

    modport source (output valid, output value_out, output status, output length,
                    input ready);
    modport sink   (input valid, input value_out, input status, input length,
                    output ready);
endinterface

>>> sv/ordered_list_store.sv
// Append, remove, clear, max on an empty list and any out-of-range or unused command:
// result valid in the cycle after acceptance. Get and max otherwise load the scan chain,
// and the read value then walks one cell per cycle down the chain towards cell 0.
// A new command may be taken in the cycle the previous result is accepted by rsp.ready.
// Reset (rst_n low, asynchronous) empties the list and drops any pending result.
module ordered_list_store (
    input  logic      clk,
    input  logic      rst_n,
    ols_cmd_if.sink   cmd,
    ols_rsp_if.source rsp
);
    import ols_pkg::*;

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [IDX_W-1:0]         step_reg, step_next;
    logic                     is_max_reg, is_max_next;
    logic                     ov_reg, ov_next;
    logic signed [DATA_W-1:0] value_out_reg, value_out_next;
    logic [STATUS_W-1:0]      status_reg, status_next;
    logic [LEN_W-1:0]         length_reg, length_next;

    cell_ctrl_t               ctrl;
    logic signed [DATA_W-1:0] entry_w [LIST_DEPTH];
    logic signed [DATA_W-1:0] scan_w  [LIST_DEPTH];
    logic                     accept;
    logic                     in_range;
    logic                     full;
    logic signed [DATA_W-1:0] scan_head;

    assign cmd.ready = (state_reg == S_IDLE) && (!ov_reg || rsp.ready);
    assign accept    = cmd.valid && cmd.ready;
    assign in_range  = (CMP_W'(cmd.position) < CMP_W'(count_reg));
    assign full      = (count_reg == CNT_W'(LIST_DEPTH));
    assign scan_head = scan_w[0];

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        step_next      = step_reg;
        is_max_next    = is_max_reg;
        ov_next        = ov_reg && !rsp.ready;
        value_out_next = value_out_reg;
        status_next    = status_reg;
        length_next    = length_reg;

        ctrl           = '0;
        ctrl.value     = cmd.value_in;
        ctrl.position  = cmd.position;
        ctrl.count     = count_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    value_out_next = '0;
                    status_next    = ST_OK;
                    ov_next        = 1'b1;
                    case (cmd.mode)
                        MODE_APPEND:
                        begin
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                ctrl.append_we = 1'b1;
                                count_next     = count_reg + CNT_W'(1);
                            end
                        end
                        MODE_GET:
                        begin
                            if (in_range)
                            begin
                                ctrl.scan_load = 1'b1;
                                step_next      = IDX_W'(cmd.position);
                                is_max_next    = 1'b0;
                                ov_next        = 1'b0;
                                state_next     = S_SCAN;
                            end
                            else
                            begin
                                status_next = ST_RANGE;
                            end
                        end
                        MODE_REMOVE:
                        begin
                            if (in_range)
                            begin
                                ctrl.remove_shift = 1'b1;
                                count_next        = count_reg - CNT_W'(1);
                            end
                            else
                            begin
                                status_next = ST_RANGE;
                            end
                        end
                        MODE_MAX:
                        begin
                            if (count_reg != '0)
                            begin
                                ctrl.scan_load = 1'b1;
                                ctrl.scan_mask = 1'b1;
                                step_next      = IDX_W'(count_reg - CNT_W'(1));
                                is_max_next    = 1'b1;
                                ov_next        = 1'b0;
                                state_next     = S_SCAN;
                            end
                        end
                        MODE_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                    length_next = LEN_W'(count_next);
                end
            end
            S_SCAN:
            begin
                if (step_reg == '0)
                begin
                    ov_next     = 1'b1;
                    status_next = ST_OK;
                    length_next = LEN_W'(count_reg);
                    if (is_max_reg && scan_head[DATA_W-1])
                    begin
                        value_out_next = '0;
                    end
                    else
                    begin
                        value_out_next = scan_head;
                    end
                    state_next = S_IDLE;
                end
                else
                begin
                    ctrl.scan_shift = !is_max_reg;
                    ctrl.scan_max   = is_max_reg;
                    step_next       = step_reg - IDX_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg      <= step_next;
        is_max_reg    <= is_max_next;
        value_out_reg <= value_out_next;
        status_reg    <= status_next;
        length_reg    <= length_next;
    end

    genvar gi;
    generate
        for (gi = 0; gi < LIST_DEPTH; gi++)
        begin : g_cell
            logic signed [DATA_W-1:0] entry_right;
            logic signed [DATA_W-1:0] scan_right;

            // the last cell is its own right-hand neighbour
            if (gi == LIST_DEPTH - 1)
            begin : g_last
                assign entry_right = entry_w[gi];
                assign scan_right  = scan_w[gi];
            end
            else
            begin : g_mid
                assign entry_right = entry_w[gi+1];
                assign scan_right  = scan_w[gi+1];
            end

            ols_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .idx         (IDX_W'(gi)),
                .entry_right (entry_right),
                .scan_right  (scan_right),
                .entry       (entry_w[gi]),
                .scan        (scan_w[gi])
            );
        end
    endgenerate

    assign rsp.valid     = ov_reg;
    assign rsp.value_out = value_out_reg;
    assign rsp.status    = status_reg;
    assign rsp.length    = length_reg;

endmodule

>>> sv/ols_cell.sv
module ols_cell (
    input  logic                             clk,
    input  ols_pkg::cell_ctrl_t              ctrl,
    input  logic [ols_pkg::IDX_W-1:0]        idx,
    input  logic signed [ols_pkg::DATA_W-1:0] entry_right,
    input  logic signed [ols_pkg::DATA_W-1:0] scan_right,
    output logic signed [ols_pkg::DATA_W-1:0] entry,
    output logic signed [ols_pkg::DATA_W-1:0] scan
);
    import ols_pkg::*;

    logic signed [DATA_W-1:0] entry_reg, entry_next;
    logic signed [DATA_W-1:0] scan_reg, scan_next;
    logic                     is_tail;
    logic                     at_or_after_pos;
    logic                     below_count;

    assign is_tail         = (CNT_W'(idx) == ctrl.count);
    assign at_or_after_pos = (CMP_W'(idx) >= CMP_W'(ctrl.position));
    assign below_count     = (CNT_W'(idx) < ctrl.count);

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.append_we && is_tail)
        begin
            entry_next = ctrl.value;
        end
        else if (ctrl.remove_shift && at_or_after_pos)
        begin
            entry_next = entry_right;
        end
    end

    always_comb
    begin
        scan_next = scan_reg;
        if (ctrl.scan_load)
        begin
            // unused cells enter the max reduction as zero
            scan_next = (ctrl.scan_mask && !below_count) ? '0 : entry_reg;
        end
        else if (ctrl.scan_shift)
        begin
            scan_next = scan_right;
        end
        else if (ctrl.scan_max)
        begin
            scan_next = (scan_right > scan_reg) ? scan_right : scan_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        scan_reg  <= scan_next;
    end

    assign entry = entry_reg;
    assign scan  = scan_reg;

endmodule

>>> sv/ols_checker.sv
module ols_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              cmd_valid,
    input logic                              cmd_ready,
    input logic [ols_pkg::MODE_W-1:0]        cmd_mode,
    input logic                              rsp_valid,
    input logic                              rsp_ready,
    input logic signed [ols_pkg::DATA_W-1:0] rsp_value_out,
    input logic [ols_pkg::STATUS_W-1:0]      rsp_status,
    input logic [ols_pkg::LEN_W-1:0]         rsp_length
);
    import ols_pkg::*;

    logic cmd_take;
    assign cmd_take = cmd_valid && cmd_ready;

    // a stalled result word holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_value_out)
                                       && $stable(rsp_status) && $stable(rsp_length)))
        else $error("result word changed while stalled");

    // never take a command while a result would be overwritten
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_ready |-> (!rsp_valid || rsp_ready))
        else $error("command taken with result slot occupied");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_take && cmd_mode == MODE_CLEAR) |=>
            (rsp_valid && rsp_length == '0 && rsp_status == ST_OK && rsp_value_out == '0))
        else $error("clear result wrong");

    a_append_quick: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_take && (cmd_mode == MODE_APPEND || cmd_mode == MODE_REMOVE)) |=> rsp_valid)
        else $error("append or remove result late");

    a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_status == ST_FULL) |-> (rsp_length == LEN_W'(LIST_DEPTH)))
        else $error("full status with list not full");

endmodule

bind ordered_list_store ols_checker u_ols_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (cmd.valid),
    .cmd_ready     (cmd.ready),
    .cmd_mode      (cmd.mode),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_value_out (rsp.value_out),
    .rsp_status    (rsp.status),
    .rsp_length    (rsp.length)
);
